// ===== src/char_lcd_nibble_sequencer_defines.svh =====
// Assertion helpers shared by the sequencer modules.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef CHAR_LCD_NIBBLE_SEQUENCER_DEFINES_SVH
`define CHAR_LCD_NIBBLE_SEQUENCER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CLNS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CLNS_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/clns_pkg.sv =====
`default_nettype none

package clns_pkg;

	// Request function codes.
	typedef enum logic [1:0] {
		FUNC_INIT   = 2'd0,
		FUNC_CMD    = 2'd1,
		FUNC_DATA   = 2'd2,
		FUNC_CURSOR = 2'd3
	} func_t;

	// Pin hold times in microseconds.
	localparam logic [15:0] HOLD_SETUP_US  = 16'd1;
	localparam logic [15:0] HOLD_NIBBLE_US = 16'd50;
	localparam logic [15:0] HOLD_LONG_US   = 16'd2050;
	localparam logic [15:0] HOLD_POWER_US  = 16'd50000;
	localparam logic [15:0] HOLD_WAKE1_US  = 16'd5050;
	localparam logic [15:0] HOLD_WAKE2_US  = 16'd1050;
	localparam logic [15:0] HOLD_WAKE3_US  = 16'd200;

	// Command bytes and cursor addressing.
	localparam logic [7:0] CMD_CLEAR       = 8'h01;
	localparam logic [7:0] CMD_HOME_ALT    = 8'h03;
	localparam logic [7:0] CMD_SET_DDRAM   = 8'h80;
	localparam logic [2:0] ROW_MAX         = 3'd3;

	// Index of the final nibble of the init sequence.
	localparam logic [3:0] INIT_LAST_IDX   = 4'd12;

	// Default depth of the job queue between front and back.
	localparam int QUEUE_DEPTH_DEF = 2;

	// One classified job handed from the front to the back.
	typedef struct packed {
		logic       is_init;
		logic       rs;
		logic [7:0] data;
		logic       long_wait;
	} job_t;

	// Queue write side.
	typedef struct packed {
		logic push;
		job_t job;
	} qwr_t;

	// Queue read side.
	typedef struct packed {
		logic valid;
		job_t job;
	} qhead_t;

	// DDRAM base address of each display row.
	function automatic logic [7:0] row_base(input logic [1:0] r);
		logic [7:0] b;
		unique case (r)
			2'd0: b = 8'h00;
			2'd1: b = 8'h40;
			2'd2: b = 8'h14;
			2'd3: b = 8'h54;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	// Nibble sent at each position of the init sequence. Position zero is the
	// power-on wait, which is a single step with all pins low.
	function automatic logic [3:0] init_nibble(input logic [3:0] idx);
		logic [3:0] n;
		unique case (idx)
			4'd0:  n = 4'h0;
			4'd1:  n = 4'h3;
			4'd2:  n = 4'h3;
			4'd3:  n = 4'h3;
			4'd4:  n = 4'h2;
			4'd5:  n = 4'h2;
			4'd6:  n = 4'h8;
			4'd7:  n = 4'h0;
			4'd8:  n = 4'hC;
			4'd9:  n = 4'h0;
			4'd10: n = 4'h1;
			4'd11: n = 4'h0;
			4'd12: n = 4'h6;
			default: n = 4'h0;
		endcase
		return n;
	endfunction

	// Final hold of each position of the init sequence.
	function automatic logic [15:0] init_hold(input logic [3:0] idx);
		logic [15:0] h;
		unique case (idx)
			4'd0:  h = HOLD_POWER_US;
			4'd1:  h = HOLD_WAKE1_US;
			4'd2:  h = HOLD_WAKE2_US;
			4'd3:  h = HOLD_WAKE3_US;
			4'd10: h = HOLD_LONG_US;
			default: h = HOLD_NIBBLE_US;
		endcase
		return h;
	endfunction

endpackage

`default_nettype wire

// ===== src/clns_ifs.sv =====
`default_nettype none

// Request channel into the sequencer.
interface clns_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] func;
	logic [7:0] value;
	logic [5:0] column;
	logic [2:0] row;

	modport source (output valid, func, value, column, row, input ready);
	modport sink (input valid, func, value, column, row, output ready);
endinterface

// Pin step channel out of the sequencer.
interface clns_step_if;
	logic        valid;
	logic        ready;
	logic        reg_select;
	logic [3:0]  data_nibble;
	logic        enable;
	logic [15:0] hold_us;
	logic        last;

	modport source (output valid, reg_select, data_nibble, enable, hold_us, last,
		input ready);
	modport sink (input valid, reg_select, data_nibble, enable, hold_us, last,
		output ready);
endinterface

`default_nettype wire

// ===== src/clns_front.sv =====
`default_nettype none

module clns_front
	import clns_pkg::*;
(
	clns_req_if.sink req,
	input  logic     q_full,
	output qwr_t     q_wr
);

	logic [1:0] row_clamped;
	logic [7:0] cursor_addr;
	job_t       job;

	// Accept a request whenever the queue has room.
	assign req.ready = !q_full;

	// Clamp the row and form the DDRAM address for set-cursor requests.
	assign row_clamped = (req.row > ROW_MAX) ? ROW_MAX[1:0] : req.row[1:0];
	assign cursor_addr = {2'b00, req.column} + row_base(row_clamped);

	// Classify the request into a job for the back end.
	always_comb begin
		job = '0;
		unique case (func_t'(req.func))
			FUNC_INIT: begin
				job.is_init = 1'b1;
			end
			FUNC_CMD: begin
				job.data      = req.value;
				job.long_wait = (req.value >= CMD_CLEAR) && (req.value <= CMD_HOME_ALT);
			end
			FUNC_DATA: begin
				job.rs   = 1'b1;
				job.data = req.value;
			end
			FUNC_CURSOR: begin
				job.data = CMD_SET_DDRAM | cursor_addr;
			end
			default: begin
				job = '0;
			end
		endcase
	end

	assign q_wr.push = req.valid && req.ready;
	assign q_wr.job  = job;

endmodule

`default_nettype wire

// ===== src/clns_queue.sv =====
`default_nettype none

module clns_queue
	import clns_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
)(
	input  logic   clk,
	input  logic   arst_n,
	input  qwr_t   q_wr,
	input  logic   pop,
	output logic   full,
	output qhead_t head
);

	`include "char_lcd_nibble_sequencer_defines.svh"

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head.valid = (count_q != '0);
	assign head.job   = entries_q[rd_ptr_q];

	// Job storage; written only on a push.
	always_ff @(posedge clk) begin
		if (q_wr.push) begin
			entries_q[wr_ptr_q] <= q_wr.job;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (q_wr.push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (q_wr.push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !q_wr.push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`CLNS_ASSERT_IMP(a_no_push_full, full, !q_wr.push, "push into a full job queue")
	`CLNS_ASSERT_IMP(a_no_pop_empty, pop, head.valid, "pop from an empty job queue")

endmodule

`default_nettype wire

// ===== src/clns_back.sv =====
`default_nettype none

module clns_back
	import clns_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  qhead_t    head,
	output logic      pop,
	clns_step_if.source step
);

	`include "char_lcd_nibble_sequencer_defines.svh"

	// Three steps of one nibble.
	typedef enum logic [2:0] {
		PH_SETUP  = 3'b001,
		PH_STROBE = 3'b010,
		PH_HOLD   = 3'b100
	} phase_t;

	phase_t      phase_q;
	logic [3:0]  nib_idx_q;

	logic        out_valid_q;
	logic        out_rs_q;
	logic [3:0]  out_nib_q;
	logic        out_en_q;
	logic [15:0] out_hold_q;
	logic        out_last_q;

	logic [3:0]  nib;
	logic [15:0] fin_hold;
	logic        single;
	logic        last_nib;
	logic        nib_done;
	logic        step_last;
	logic        advance;

	// Work out the pin levels of the current step of the head job.
	always_comb begin
		if (head.job.is_init) begin
			nib      = init_nibble(nib_idx_q);
			fin_hold = init_hold(nib_idx_q);
			single   = (nib_idx_q == '0);
			last_nib = (nib_idx_q == INIT_LAST_IDX);
		end else begin
			nib      = nib_idx_q[0] ? head.job.data[3:0] : head.job.data[7:4];
			fin_hold = (nib_idx_q[0] && head.job.long_wait) ? HOLD_LONG_US : HOLD_NIBBLE_US;
			single   = 1'b0;
			last_nib = nib_idx_q[0];
		end
		nib_done  = single || (phase_q == PH_HOLD);
		step_last = nib_done && last_nib;
	end

	// A step is produced whenever a job is at the head of the queue and the output register is free or being drained.
	assign advance = head.valid && (!out_valid_q || step.ready);
	assign pop     = advance && step_last;

	// Nibble position and phase counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_SETUP;
			nib_idx_q <= '0;
		end else if (advance) begin
			if (nib_done) begin
				phase_q   <= PH_SETUP;
				nib_idx_q <= last_nib ? '0 : nib_idx_q + 1'b1;
			end else begin
				unique case (phase_q)
					PH_SETUP:  phase_q <= PH_STROBE;
					PH_STROBE: phase_q <= PH_HOLD;
					PH_HOLD:   phase_q <= PH_SETUP;
					default:   phase_q <= PH_SETUP;
				endcase
			end
		end
	end

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (step.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (advance) begin
			out_rs_q   <= head.job.rs;
			out_nib_q  <= nib;
			out_en_q   <= (phase_q == PH_STROBE);
			out_hold_q <= nib_done ? fin_hold : HOLD_SETUP_US;
			out_last_q <= step_last;
		end
	end

	assign step.valid       = out_valid_q;
	assign step.reg_select  = out_rs_q;
	assign step.data_nibble = out_nib_q;
	assign step.enable      = out_en_q;
	assign step.hold_us     = out_hold_q;
	assign step.last        = out_last_q;

	`CLNS_ASSERT_NXT(a_pop_marks_last, pop, out_valid_q && out_last_q, "job retired without last step")
	`CLNS_ASSERT_IMP(a_idx_range, 1'b1, nib_idx_q <= INIT_LAST_IDX, "nibble position out of range")
	`CLNS_ASSERT_IMP(a_mid_job_head, phase_q != PH_SETUP || nib_idx_q != '0, head.valid, "sequencer mid-job without a job")

endmodule

`default_nettype wire

// ===== src/char_lcd_nibble_sequencer.sv =====
// Character LCD nibble sequencer for a 4-bit HD44780-style bus. Each request
// (init, command byte, data byte, set cursor) becomes a list of pin steps, one
// step per output request, each giving RS, D4..D7, E and the hold time in
// microseconds, with last set on the final step. A byte request or a
// set-cursor request yields six steps and an init request 37 steps. The back
// sequencer emits one step per cycle while the output is taken; that
// sequencer sets the throughput. A small job queue in front of it keeps
// accepting requests while it has room and steps of earlier ones are still
// going out, and the block keeps no state between requests.
`default_nettype none

module char_lcd_nibble_sequencer
	import clns_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)(
	input  logic        clk,
	input  logic        arst_n,
	clns_req_if.sink    req,
	clns_step_if.source step
);

	qwr_t   q_wr;
	qhead_t q_head;
	logic   q_full;
	logic   q_pop;

	// Classifies requests into jobs.
	clns_front u_front (
		.req    (req),
		.q_full (q_full),
		.q_wr   (q_wr)
	);

	// Decouples request acceptance from step generation.
	clns_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.q_wr   (q_wr),
		.pop    (q_pop),
		.full   (q_full),
		.head   (q_head)
	);

	// Expands each job into timed pin steps.
	clns_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (q_head),
		.pop    (q_pop),
		.step   (step)
	);

endmodule

`default_nettype wire

// ===== test/lcd_step_checker.sv =====
`timescale 1ns / 100ps

module lcd_step_checker
	import clns_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	clns_req_if         req,
	clns_step_if        step,
	output int          fail_count,
	output int          pending_steps,
	output int          steps_checked
);

	// One pin step as the LCD bus should see it.
	typedef struct packed {
		logic        reg_select;
		logic [3:0]  data_nibble;
		logic        enable;
		logic [15:0] hold_us;
		logic        last;
	} lcd_step_t;

	lcd_step_t expected_steps [$];

	// Prints one line per mismatch, up to a cap, and counts every one.
	task automatic report_mismatch(input string what);
		if (fail_count < 30) begin
			$display("[%0t] step check: %s", $time, what);
		end
		fail_count++;
	endtask

	function automatic lcd_step_t make_step(input logic rs, input logic [3:0] nib,
		input logic en, input logic [15:0] hold);
		lcd_step_t s;
		s.reg_select  = rs;
		s.data_nibble = nib;
		s.enable      = en;
		s.hold_us     = hold;
		s.last        = 1'b0;
		return s;
	endfunction

	// A nibble is set up, strobed, then held; extra time goes on the final hold.
	task automatic queue_nibble(input logic rs, input logic [3:0] nib,
		input logic [15:0] extra);
		expected_steps.push_back(make_step(rs, nib, 1'b0, 16'd1));
		expected_steps.push_back(make_step(rs, nib, 1'b1, 16'd1));
		expected_steps.push_back(make_step(rs, nib, 1'b0, 16'd50 + extra));
	endtask

	// A byte goes out high nibble first.
	task automatic queue_byte(input logic rs, input logic [7:0] b, input logic [15:0] extra);
		queue_nibble(rs, b[7:4], 16'd0);
		queue_nibble(rs, b[3:0], extra);
	endtask

	// DDRAM address for a cursor position; rows above the last one are clamped.
	function automatic logic [7:0] cursor_address(input logic [5:0] col, input logic [2:0] r);
		logic [7:0] offset;
		case (r)
			3'd0: offset = 8'h00;
			3'd1: offset = 8'h40;
			3'd2: offset = 8'h14;
			default: offset = 8'h54;
		endcase
		return 8'h80 | (8'(col) + offset);
	endfunction

	// Expands one accepted request into the pin steps it must produce.
	task automatic predict_request(input func_t f, input logic [7:0] v,
		input logic [5:0] c, input logic [2:0] r);
		case (f)
			FUNC_INIT: begin
				expected_steps.push_back(make_step(1'b0, 4'h0, 1'b0, 16'd50000));
				queue_nibble(1'b0, 4'h3, 16'd5000);
				queue_nibble(1'b0, 4'h3, 16'd1000);
				queue_nibble(1'b0, 4'h3, 16'd150);
				queue_nibble(1'b0, 4'h2, 16'd0);
				queue_byte(1'b0, 8'h28, 16'd0);
				queue_byte(1'b0, 8'h0C, 16'd0);
				queue_byte(1'b0, 8'h01, 16'd2000);
				queue_byte(1'b0, 8'h06, 16'd0);
			end
			FUNC_CMD: begin
				// Clear and home need the long wait on their final hold.
				queue_byte(1'b0, v, (v >= 8'd1 && v <= 8'd3) ? 16'd2000 : 16'd0);
			end
			FUNC_DATA: queue_byte(1'b1, v, 16'd0);
			default: queue_byte(1'b0, cursor_address(c, r), 16'd0);
		endcase
		expected_steps[expected_steps.size() - 1].last = 1'b1;
	endtask

	// Compares one accepted step with the oldest expected one, field by field.
	task automatic check_step();
		lcd_step_t want;
		if (expected_steps.size() == 0) begin
			report_mismatch("step arrived with nothing expected");
			return;
		end
		want = expected_steps.pop_front();
		if (step.reg_select !== want.reg_select)
			report_mismatch($sformatf("reg_select %0b, expected %0b",
				step.reg_select, want.reg_select));
		if (step.data_nibble !== want.data_nibble)
			report_mismatch($sformatf("data_nibble %h, expected %h",
				step.data_nibble, want.data_nibble));
		if (step.enable !== want.enable)
			report_mismatch($sformatf("enable %0b, expected %0b", step.enable, want.enable));
		if (step.hold_us !== want.hold_us)
			report_mismatch($sformatf("hold_us %0d, expected %0d", step.hold_us, want.hold_us));
		if (step.last !== want.last)
			report_mismatch($sformatf("last %0b, expected %0b", step.last, want.last));
		steps_checked++;
	endtask

	// Prediction runs before comparison so a request and its steps never race.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_steps.delete();
			fail_count    = 0;
			steps_checked = 0;
		end else begin
			if (req.valid === 1'b1 && req.ready === 1'b1) begin
				predict_request(func_t'(req.func), req.value, req.column, req.row);
			end
			if (step.valid === 1'b1 && step.ready === 1'b1) begin
				check_step();
			end
		end
		pending_steps = expected_steps.size();
	end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;
	import clns_pkg::*;

	logic clk;
	logic arst_n;
	int   sender_idle_pct;
	int   receiver_stall_pct;
	int   func_count [4];
	int   fail_count;
	int   pending_steps;
	int   steps_checked;

	clns_req_if  req_ch ();
	clns_step_if step_ch ();

	char_lcd_nibble_sequencer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.step   (step_ch)
	);

	lcd_step_checker step_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (req_ch),
		.step          (step_ch),
		.fail_count    (fail_count),
		.pending_steps (pending_steps),
		.steps_checked (steps_checked)
	);

	// Clock generator.
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Watchdog for a hung sequencer.
	initial begin
		#8_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// The step receiver stalls at random according to the current phase.
	initial begin
		step_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (receiver_stall_pct > 0 && $urandom_range(99) < receiver_stall_pct)
				step_ch.ready <= 1'b0;
			else
				step_ch.ready <= 1'b1;
		end
	end

	// Offers one request, with random idle cycles first, and waits for it to be taken.
	task automatic send_request(input func_t f, input logic [7:0] v,
		input logic [5:0] c, input logic [2:0] r);
		while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid  <= 1'b1;
		req_ch.func   <= f;
		req_ch.value  <= v;
		req_ch.column <= c;
		req_ch.row    <= r;
		@(posedge clk);
		while (req_ch.ready !== 1'b1) @(posedge clk);
		func_count[int'(f)]++;
	endtask

	// Mostly byte and cursor requests, with the occasional full init.
	task automatic send_random_request();
		int          pick;
		func_t       f;
		logic [7:0]  v;
		logic [5:0]  c;
		logic [2:0]  r;
		pick = $urandom_range(99);
		v = 8'($urandom);
		c = 6'($urandom);
		r = 3'($urandom);
		if (pick < 8) f = FUNC_INIT;
		else if (pick < 38) f = FUNC_CMD;
		else if (pick < 68) f = FUNC_DATA;
		else f = FUNC_CURSOR;
		// Bias commands toward the clear and home codes and their neighbors.
		if (f == FUNC_CMD && $urandom_range(3) == 0) v = 8'($urandom_range(4));
		// Half the cursor moves are kept to columns 0 to 39 and rows 0 to 3.
		if (f == FUNC_CURSOR && $urandom_range(1) == 0) begin
			c = 6'($urandom_range(39));
			r = 3'($urandom_range(3));
		end
		send_request(f, v, c, r);
	endtask

	// Stops offering requests until every expected step has come out.
	task automatic hold_off_until_drained();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_steps != 0) @(posedge clk);
	endtask

	// Main stimulus: reset, directed corners, then four idle/stall phases.
	initial begin
		req_ch.valid       <= 1'b0;
		req_ch.func        <= FUNC_INIT;
		req_ch.value       <= 8'h00;
		req_ch.column      <= 6'd0;
		req_ch.row         <= 3'd0;
		arst_n             <= 1'b0;
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		foreach (func_count[i]) func_count[i] = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed corners: init, clear/home codes, byte extremes, cursor clamping.
		send_request(FUNC_INIT,   8'h00, 6'd0,  3'd0);
		send_request(FUNC_CMD,    8'h00, 6'd63, 3'd7);
		send_request(FUNC_CMD,    8'h01, 6'd0,  3'd0);
		send_request(FUNC_CMD,    8'h02, 6'd0,  3'd0);
		send_request(FUNC_CMD,    8'h03, 6'd0,  3'd0);
		send_request(FUNC_CMD,    8'h04, 6'd0,  3'd0);
		send_request(FUNC_CMD,    8'hFF, 6'd0,  3'd0);
		send_request(FUNC_DATA,   8'h00, 6'd63, 3'd7);
		send_request(FUNC_DATA,   8'hFF, 6'd0,  3'd0);
		send_request(FUNC_DATA,   8'h01, 6'd0,  3'd0);
		send_request(FUNC_DATA,   8'hA5, 6'd0,  3'd0);
		send_request(FUNC_CURSOR, 8'hFF, 6'd0,  3'd0);
		send_request(FUNC_CURSOR, 8'h00, 6'd39, 3'd1);
		send_request(FUNC_CURSOR, 8'h00, 6'd19, 3'd2);
		send_request(FUNC_CURSOR, 8'h00, 6'd39, 3'd3);
		send_request(FUNC_CURSOR, 8'h00, 6'd5,  3'd4);
		send_request(FUNC_CURSOR, 8'h00, 6'd63, 3'd7);
		send_request(FUNC_CURSOR, 8'h00, 6'd63, 3'd3);
		send_request(FUNC_CURSOR, 8'h00, 6'd42, 3'd5);
		send_request(FUNC_INIT,   8'hFF, 6'd63, 3'd7);
		hold_off_until_drained();

		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
				1: begin sender_idle_pct = 71; receiver_stall_pct = 0;  end
				2: begin sender_idle_pct = 0;  receiver_stall_pct = 71; end
				default: begin sender_idle_pct = 9; receiver_stall_pct = 9; end
			endcase
			for (int i = 0; i < 48; i++) send_random_request();
			// Let the sequencer run dry once mid-run before moving on.
			if (p == 1) hold_off_until_drained();
		end

		hold_off_until_drained();
		repeat (40) @(posedge clk);

		$display("Covered %0d init, %0d command, %0d data and %0d set-cursor requests,",
			func_count[0], func_count[1], func_count[2], func_count[3]);
		$display("with %0d pin steps checked across idle, sender-gap and receiver-stall mixes.",
			steps_checked);
		if (fail_count == 0 && pending_steps == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
